### hdl/bump_heap_allocator_unit_defines.svh
// Assertion macros used by the allocator back stage.
`ifndef BUMP_HEAP_ALLOCATOR_UNIT_DEFINES_SVH
`define BUMP_HEAP_ALLOCATOR_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define BHA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define BHA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/bha_pkg.sv
// Types and constants shared by the bump heap allocator modules.
`default_nettype none

package bha_pkg;

    localparam int ADDR_W = 32;
    localparam int HDR_W  = 13;
    localparam int CNT_W  = 16;

    localparam logic [ADDR_W-1:0] RST_REGION_LO   = 32'd0;
    localparam logic [ADDR_W-1:0] RST_REGION_HI   = 32'd4194304;
    localparam logic [HDR_W-1:0]  RST_HEADER_SIZE = 13'd64;
    localparam logic [CNT_W-1:0]  RST_MAX_BLOCKS  = 16'd256;

    localparam logic [1:0] REG_REGION_LO   = 2'd0;
    localparam logic [1:0] REG_REGION_HI   = 2'd1;
    localparam logic [1:0] REG_HEADER_SIZE = 2'd2;
    localparam logic [1:0] REG_MAX_BLOCKS  = 2'd3;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_EMPTY   = 3'd1,
        ST_ZERO    = 3'd2,
        ST_LARGE   = 3'd3,
        ST_LIMIT   = 3'd4,
        ST_BADLAST = 3'd5
    } status_t;

    typedef struct packed {
        logic [ADDR_W-1:0] region_lo;
        logic [ADDR_W-1:0] region_hi;
        logic [HDR_W-1:0]  header_size;
        logic [CNT_W-1:0]  max_blocks;
    } cfg_t;

    // A request as classified by the front: the size and its offsets.
    typedef struct packed {
        logic [ADDR_W-1:0] size;
        logic [ADDR_W-1:0] hs_sz;      // header plus size
        logic [ADDR_W-1:0] end_ofs;    // header plus size plus size
        logic              zero;
    } item_t;

    typedef struct packed {
        status_t           status;
        logic [ADDR_W-1:0] user_address;
        logic [ADDR_W-1:0] header_address;
        logic [ADDR_W-1:0] end_address;
        logic [CNT_W-1:0]  block_id;
    } result_t;

endpackage

`default_nettype wire

### hdl/bha_front.sv
// Front stage: accepts request words and precomputes the size offsets.
`default_nettype none

module bha_front (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    input  wire logic [bha_pkg::ADDR_W-1:0] s_tdata,
    input  wire logic [bha_pkg::HDR_W-1:0]  header_size,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output bha_pkg::item_t                out_item
);

    logic           valid_reg;
    logic           valid_next;
    bha_pkg::item_t item_reg;
    bha_pkg::item_t item_next;
    logic           accept;

    assign s_tready = !valid_reg || out_ready;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        item_next.size    = s_tdata;
        item_next.hs_sz   = s_tdata + {{(bha_pkg::ADDR_W-bha_pkg::HDR_W){1'b0}}, header_size};
        item_next.end_ofs = item_next.hs_sz + s_tdata;
        item_next.zero    = (s_tdata == '0);
    end

    always_comb
    begin
        if (accept)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= item_next;
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

`default_nettype wire

### hdl/bha_queue.sv
// Short queue between the front and back stages.
`default_nettype none

module bha_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire bha_pkg::item_t in_item,
    output logic         out_valid,
    input  wire logic    out_ready,
    output bha_pkg::item_t out_item
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int FILL_W = $clog2(DEPTH + 1);

    bha_pkg::item_t    mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic              push;
    logic              pop;

    assign in_ready  = (fill_reg != FILL_W'(DEPTH));
    assign out_valid = (fill_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_item  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            fill_next = fill_reg + 1'b1;
        else if (pop && !push)
            fill_next = fill_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= in_item;
    end

endmodule

`default_nettype wire

### hdl/bha_back.sv
// Back stage: holds the heap state, carries out requests, registers results.
`default_nettype none
`include "bump_heap_allocator_unit_defines.svh"

module bha_back (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire bha_pkg::cfg_t  cfg,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire bha_pkg::item_t in_item,
    output logic           m_valid,
    input  wire logic      m_ready,
    output bha_pkg::result_t m_result
);

    localparam int AW = bha_pkg::ADDR_W;
    localparam int CW = bha_pkg::CNT_W;

    logic [AW-1:0]    np_reg;
    logic [AW-1:0]    np_next;
    logic [AW-1:0]    avail_reg;
    logic [AW-1:0]    avail_next;
    logic [AW-1:0]    lvp_reg;
    logic [AW-1:0]    lvp_next;
    logic [CW-1:0]    cnt_reg;
    logic [CW-1:0]    cnt_next;
    logic             valid_reg;
    logic             valid_next;
    bha_pkg::result_t result_reg;
    bha_pkg::result_t result_next;

    logic          take;
    logic          np_in;
    logic          lvp_in;
    logic          retry_in;
    logic [AW-1:0] retry_ptr;
    logic [AW-1:0] end_direct;
    logic [AW-1:0] end_retry;
    logic [CW-1:0] cnt_one;
    logic [CW-1:0] cnt_two;
    logic [AW-1:0] hdr_ext;
    logic          res_ok;
    logic          res_fail;
    logic          res_clear;
    logic          user_match;
    logic          take_ok;
    logic          np_at_end;
    logic [AW-1:0] avail_dec;

    assign in_ready = !valid_reg || m_ready;
    assign take     = in_valid && in_ready;
    assign hdr_ext  = {{(AW-bha_pkg::HDR_W){1'b0}}, cfg.header_size};

    // All candidate pointers and compares are formed in parallel.
    assign retry_ptr  = lvp_reg + in_item.size;
    assign end_direct = np_reg + in_item.hs_sz;
    assign end_retry  = lvp_reg + in_item.end_ofs;
    assign np_in      = (np_reg >= cfg.region_lo) && (np_reg < cfg.region_hi);
    assign lvp_in     = (lvp_reg >= cfg.region_lo) && (lvp_reg < cfg.region_hi);
    assign retry_in   = (retry_ptr >= cfg.region_lo) && (retry_ptr < cfg.region_hi);
    assign cnt_one    = cnt_reg + CW'(1);
    assign cnt_two    = cnt_reg + CW'(2);

    always_comb
    begin
        np_next    = np_reg;
        avail_next = avail_reg;
        lvp_next   = lvp_reg;
        cnt_next   = cnt_reg;
        result_next = '0;
        result_next.status = bha_pkg::ST_OK;
        if (avail_reg == '0)
            result_next.status = bha_pkg::ST_EMPTY;
        else if (in_item.zero)
        begin
            result_next.status       = bha_pkg::ST_ZERO;
            result_next.user_address = np_reg;
        end
        else if (in_item.size >= avail_reg)
            result_next.status = bha_pkg::ST_LARGE;
        else if (cnt_one >= cfg.max_blocks)
        begin
            result_next.status = bha_pkg::ST_LIMIT;
            cnt_next           = cnt_one;
        end
        else if (np_in)
        begin
            cnt_next   = cnt_one;
            lvp_next   = np_reg;
            np_next    = end_direct;
            avail_next = avail_reg - in_item.hs_sz;
            result_next.header_address = np_reg;
            result_next.user_address   = np_reg + hdr_ext;
            result_next.end_address    = end_direct;
            result_next.block_id       = cnt_one;
        end
        else if (!lvp_in)
        begin
            result_next.status = bha_pkg::ST_BADLAST;
            cnt_next           = cnt_one;
        end
        else if (cnt_two >= cfg.max_blocks)
        begin
            result_next.status = bha_pkg::ST_LIMIT;
            cnt_next           = cnt_two;
            np_next            = retry_ptr;
        end
        else if (!retry_in)
        begin
            // A recovered pointer that is still outside would loop until the limit.
            result_next.status = bha_pkg::ST_LIMIT;
            cnt_next           = cfg.max_blocks;
            np_next            = retry_ptr;
        end
        else
        begin
            cnt_next   = cnt_two;
            lvp_next   = retry_ptr;
            np_next    = end_retry;
            avail_next = avail_reg - in_item.hs_sz;
            result_next.header_address = retry_ptr;
            result_next.user_address   = retry_ptr + hdr_ext;
            result_next.end_address    = end_retry;
            result_next.block_id       = cnt_two;
        end
    end

    always_comb
    begin
        if (take)
            valid_next = 1'b1;
        else if (m_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            np_reg    <= bha_pkg::RST_REGION_LO;
            avail_reg <= bha_pkg::RST_REGION_HI - bha_pkg::RST_REGION_LO;
            lvp_reg   <= bha_pkg::RST_REGION_LO;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (take)
            begin
                np_reg    <= np_next;
                avail_reg <= avail_next;
                lvp_reg   <= lvp_next;
                cnt_reg   <= cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            result_reg <= result_next;
    end

    assign m_valid  = valid_reg;
    assign m_result = result_reg;

    assign res_ok     = valid_reg && (result_reg.status == bha_pkg::ST_OK);
    assign res_fail   = valid_reg && (result_reg.status != bha_pkg::ST_OK);
    assign res_clear  = (result_reg.header_address == '0) && (result_reg.end_address == '0)
                        && (result_reg.block_id == '0);
    assign user_match = (result_reg.user_address == result_reg.header_address + hdr_ext);
    assign take_ok    = take && (result_next.status == bha_pkg::ST_OK);
    assign np_at_end  = (np_reg == result_reg.end_address);
    assign avail_dec  = avail_reg - in_item.hs_sz;

    `BHA_ASSERT_NOW(a_fail_zeroed, res_fail, res_clear, "failed allocation carries nonzero fields")
    `BHA_ASSERT_NOW(a_user_after_header, res_ok, user_match, "user address not past the header")
    `BHA_ASSERT_NEXT(a_avail_drop, take_ok, avail_reg == $past(avail_dec), "available count not reduced")
    `BHA_ASSERT_NEXT(a_ptr_to_end, take_ok, np_at_end, "pointer not moved to the end address")

endmodule

`default_nettype wire

### hdl/bump_heap_allocator_unit.sv
// Bump heap allocator top level: configuration registers and stream channels.
//
// Each request word on the slave stream carries one request size in bytes. For
// every request exactly one result word leaves on the master stream, in order:
// the status code in m_tuser and the user, header and end addresses and the
// block id in m_tdata. Fields of a failed request read as zero, except that a
// zero-size request returns the current pointer as its user address.
// A request passes a front register, a queue of QUEUE_DEPTH entries and the
// back stage, whose output register holds the result. One request is accepted
// per cycle while s_tready is high; the back stage registers the heap state
// update together with the result.
// When the receiver stalls, the result register holds and the queue fills,
// after which s_tready drops; no word is lost or repeated.
// Reset clears the queue and loads the heap state from the register reset
// values: pointer at the region start, the whole heap available, counter at zero.
// The APB registers are the region start (0x0), the region end (0x4), the
// header size (0x8) and the block limit (0xC); writes take effect on the next
// request and do not reload the heap state. Write registers only while idle.
`default_nettype none

module bump_heap_allocator_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    // APB configuration port
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [3:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    // Request stream
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [31:0]  s_tdata,   // [31:0] request_size
    // Result stream
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [111:0]      m_tdata,   // [31:0] user_address, [63:32] header_address,
                                         // [95:64] end_address, [111:96] block_id
    output logic [2:0]        m_tuser    // [2:0] status
);

    bha_pkg::cfg_t    cfg_reg;
    bha_pkg::item_t   front_item;
    bha_pkg::item_t   queue_item;
    bha_pkg::result_t result;
    logic             front_valid;
    logic             front_ready;
    logic             queue_valid;
    logic             queue_ready;
    logic             cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.region_lo   <= bha_pkg::RST_REGION_LO;
            cfg_reg.region_hi   <= bha_pkg::RST_REGION_HI;
            cfg_reg.header_size <= bha_pkg::RST_HEADER_SIZE;
            cfg_reg.max_blocks  <= bha_pkg::RST_MAX_BLOCKS;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                bha_pkg::REG_REGION_LO:   cfg_reg.region_lo   <= pwdata;
                bha_pkg::REG_REGION_HI:   cfg_reg.region_hi   <= pwdata;
                bha_pkg::REG_HEADER_SIZE: cfg_reg.header_size <= pwdata[bha_pkg::HDR_W-1:0];
                bha_pkg::REG_MAX_BLOCKS:  cfg_reg.max_blocks  <= pwdata[bha_pkg::CNT_W-1:0];
                default:                  ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            bha_pkg::REG_REGION_LO:   prdata = cfg_reg.region_lo;
            bha_pkg::REG_REGION_HI:   prdata = cfg_reg.region_hi;
            bha_pkg::REG_HEADER_SIZE: prdata = {{(32-bha_pkg::HDR_W){1'b0}}, cfg_reg.header_size};
            bha_pkg::REG_MAX_BLOCKS:  prdata = {{(32-bha_pkg::CNT_W){1'b0}}, cfg_reg.max_blocks};
            default:                  prdata = '0;
        endcase
    end

    bha_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .header_size (cfg_reg.header_size),
        .out_valid   (front_valid),
        .out_ready   (front_ready),
        .out_item    (front_item)
    );

    bha_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_item   (front_item),
        .out_valid (queue_valid),
        .out_ready (queue_ready),
        .out_item  (queue_item)
    );

    bha_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (queue_valid),
        .in_ready (queue_ready),
        .in_item  (queue_item),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_result (result)
    );

    assign m_tdata = {result.block_id, result.end_address,
                      result.header_address, result.user_address};
    assign m_tuser = result.status;

endmodule

`default_nettype wire
